// ----- hdl/stfl_pkg.sv -----
// Shared constants for the sorted table floor lookup block.
package stfl_pkg;

    localparam int CAPACITY_DEF      = 256;
    localparam int KEY_WIDTH_DEF     = 32;
    localparam int PAYLOAD_WIDTH_DEF = 32;

    localparam int FIELD_W   = 32;
    localparam int HELD_W    = 9;
    localparam int TUSER_W   = 2;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 80;
    localparam int M_PAD_W   = M_TDATA_W - 2 * FIELD_W - HELD_W;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

endpackage

// ----- hdl/sorted_table_floor_lookup.sv -----
// Sorted key/payload table with append, clear and floor search.
//
// Usage: each input word carries a command in s_axis_tuser (clear, append,
// floor search) and a key and payload in s_axis_tdata. Exactly one result
// word leaves on the m_axis channel per input word: a status in
// m_axis_tuser, and the found key, found payload and table fill in
// m_axis_tdata. Entries are kept in ascending key order in one synchronous
// memory; equal keys keep their arrival order.
// One command is worked on at a time. Clear, unused and full-append commands
// go from accept straight to the result state. Search and append run an
// upper-bound binary search through the memory's single read port, each
// probe a read state then a compare state. An append then moves the entries
// above its slot up by one, one entry per cycle through the read and write
// ports. s_axis_tready is high only while no command is in work.
// Reset clears the fill count and the output valid flag; the memory is not
// cleared, as only entries below the fill count are ever read.
// A result waiting on a stalled receiver sits in the output register; the
// next command is accepted meanwhile and holds its result until the slot
// frees.
module sorted_table_floor_lookup
    import stfl_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int KEY_WIDTH     = KEY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [31:0] entry_key, [63:32] entry_payload
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] mode
    input  logic [TUSER_W-1:0]   s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [31:0] found_key, [63:32] found_payload, [72:64] entries_held, rest 0
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [TUSER_W-1:0]   m_axis_tuser
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = KEY_WIDTH + PAYLOAD_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_SHIFT,
        S_RESP
    } state_t;

    state_t                   state_reg;
    logic [1:0]               mode_reg;
    logic [KEY_WIDTH-1:0]     q_reg;
    logic [PAYLOAD_WIDTH-1:0] pay_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            lo_reg;
    logic [CW-1:0]            hi_reg;
    logic [CW-1:0]            mid_reg;
    logic [CW-1:0]            i_reg;
    logic [AW-1:0]            w_reg;
    logic                     pend_reg;
    logic [DW-1:0]            cand_reg;
    logic [1:0]               res_status_reg;
    logic [KEY_WIDTH-1:0]     res_key_reg;
    logic [PAYLOAD_WIDTH-1:0] res_pay_reg;
    logic                     m_valid_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;
    logic [TUSER_W-1:0]       m_tuser_reg;

    logic [DW-1:0]            table_mem [CAPACITY];
    logic [DW-1:0]            rd_data_reg;

    logic [CW:0]              mid_sum;
    logic [CW-1:0]            mid;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [DW-1:0]            mem_wdata;
    logic [AW-1:0]            mem_raddr;
    logic [CW-1:0]            i_dec;
    logic                     s_fire;
    logic                     key_le;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CW:1];
    assign i_dec   = i_reg - 1'b1;
    assign key_le  = (rd_data_reg[KEY_WIDTH-1:0] <= q_reg);

    always_comb begin
        mem_raddr = mid[AW-1:0];
        if (state_reg == S_SHIFT) begin
            mem_raddr = i_dec[AW-1:0];
        end
        mem_we    = (state_reg == S_SHIFT) && (pend_reg || (i_reg <= lo_reg));
        mem_waddr = pend_reg ? w_reg : lo_reg[AW-1:0];
        mem_wdata = pend_reg ? rd_data_reg : {pay_reg, q_reg};
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= table_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_axis_tready && (state_reg != S_RESP)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        mode_reg       <= s_axis_tuser;
                        q_reg          <= KEY_WIDTH'(s_axis_tdata[FIELD_W-1:0]);
                        pay_reg        <= PAYLOAD_WIDTH'(s_axis_tdata[2*FIELD_W-1:FIELD_W]);
                        res_status_reg <= ST_OK;
                        res_key_reg    <= '0;
                        res_pay_reg    <= '0;
                        lo_reg         <= '0;
                        hi_reg         <= count_reg;
                        unique case (s_axis_tuser)
                            MODE_CLEAR: begin
                                count_reg <= '0;
                                state_reg <= S_RESP;
                            end
                            MODE_APPEND: begin
                                if (count_reg == CW'(CAPACITY)) begin
                                    res_status_reg <= ST_FULL;
                                    state_reg      <= S_RESP;
                                end else begin
                                    state_reg <= S_SRCH;
                                end
                            end
                            MODE_SEARCH: begin
                                state_reg <= S_SRCH;
                            end
                            default: begin
                                state_reg <= S_RESP;
                            end
                        endcase
                    end
                end
                S_SRCH: begin
                    if (lo_reg < hi_reg) begin
                        mid_reg   <= mid;
                        state_reg <= S_CMP;
                    end else if (mode_reg == MODE_APPEND) begin
                        i_reg     <= count_reg;
                        pend_reg  <= 1'b0;
                        state_reg <= S_SHIFT;
                    end else begin
                        if (lo_reg == '0) begin
                            res_status_reg <= ST_NOT_FOUND;
                        end else begin
                            res_key_reg <= cand_reg[KEY_WIDTH-1:0];
                            res_pay_reg <= cand_reg[DW-1:KEY_WIDTH];
                        end
                        state_reg <= S_RESP;
                    end
                end
                S_CMP: begin
                    if (key_le) begin
                        lo_reg   <= mid_reg + 1'b1;
                        cand_reg <= rd_data_reg;
                    end else begin
                        hi_reg <= mid_reg;
                    end
                    state_reg <= S_SRCH;
                end
                S_SHIFT: begin
                    if (i_reg > lo_reg) begin
                        w_reg    <= i_reg[AW-1:0];
                        i_reg    <= i_dec;
                        pend_reg <= 1'b1;
                    end else if (pend_reg) begin
                        pend_reg <= 1'b0;
                    end else begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_valid_reg <= 1'b1;
                        m_tuser_reg <= res_status_reg;
                        m_tdata_reg <= {{M_PAD_W{1'b0}}, HELD_W'(count_reg),
                                        FIELD_W'(res_pay_reg), FIELD_W'(res_key_reg)};
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SRCH) |-> (lo_reg <= hi_reg) && (hi_reg <= count_reg))
        else $error("search window out of range");

    a_shift_dest: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT) && pend_reg |->
            (CW'(w_reg) > lo_reg) && (CW'(w_reg) <= count_reg))
        else $error("shift write outside moved range");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_axis_tready)
        else $error("second word taken while one is in work");
`endif

endmodule

// ----- dv/stfl_lookup_scoreboard_pkg.sv -----
// Scoreboard for the sorted table floor lookup: table predictor and result checks.
package stfl_lookup_scoreboard_pkg;

    import stfl_pkg::*;

    typedef struct packed {
        logic [1:0]        status;
        logic [FIELD_W-1:0] found_key;
        logic [FIELD_W-1:0] found_payload;
        logic [HELD_W-1:0]  entries_held;
    } lookup_result_t;

    class lookup_scoreboard;

        logic [FIELD_W-1:0] key_store[CAPACITY_DEF];
        logic [FIELD_W-1:0] payload_store[CAPACITY_DEF];
        int unsigned        fill;
        lookup_result_t     expected_results[$];
        int unsigned        error_count;

        function new();
            fill        = 0;
            error_count = 0;
        endfunction

        // entries with key not above k; the store is sorted, so this is the floor slot + 1
        function int unsigned count_not_above(logic [FIELD_W-1:0] k);
            int unsigned n;
            n = 0;
            while (n < fill && key_store[n] <= k)
                n++;
            return n;
        endfunction

        function void note_command(logic [1:0] mode, logic [FIELD_W-1:0] key,
                                   logic [FIELD_W-1:0] payload);
            lookup_result_t r;
            int unsigned    pos;
            int unsigned    i;
            r        = '0;
            r.status = ST_OK;
            case (mode)
                MODE_CLEAR: begin
                    fill = 0;
                end
                MODE_APPEND: begin
                    if (fill >= CAPACITY_DEF) begin
                        r.status = ST_FULL;
                    end else begin
                        pos = count_not_above(key);
                        for (i = fill; i > pos; i--) begin
                            key_store[i]     = key_store[i-1];
                            payload_store[i] = payload_store[i-1];
                        end
                        key_store[pos]     = key;
                        payload_store[pos] = payload;
                        fill++;
                    end
                end
                MODE_SEARCH: begin
                    pos = count_not_above(key);
                    if (pos == 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        r.found_key     = key_store[pos-1];
                        r.found_payload = payload_store[pos-1];
                    end
                end
                default: ;
            endcase
            r.entries_held = fill[HELD_W-1:0];
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [TUSER_W-1:0] tuser, logic [M_TDATA_W-1:0] tdata);
            lookup_result_t exp_r;
            logic [M_PAD_W-1:0] pad;
            if (expected_results.size() == 0) begin
                $error("result word with no command outstanding: tuser %0h tdata %0h",
                       tuser, tdata);
                error_count++;
                return;
            end
            exp_r = expected_results.pop_front();
            pad   = tdata[M_TDATA_W-1 -: M_PAD_W];
            if (tuser !== exp_r.status) begin
                $error("status expected %0h actual %0h", exp_r.status, tuser);
                error_count++;
            end
            if (tdata[FIELD_W-1:0] !== exp_r.found_key) begin
                $error("found_key expected %0h actual %0h", exp_r.found_key,
                       tdata[FIELD_W-1:0]);
                error_count++;
            end
            if (tdata[2*FIELD_W-1:FIELD_W] !== exp_r.found_payload) begin
                $error("found_payload expected %0h actual %0h", exp_r.found_payload,
                       tdata[2*FIELD_W-1:FIELD_W]);
                error_count++;
            end
            if (tdata[2*FIELD_W +: HELD_W] !== exp_r.entries_held) begin
                $error("entries_held expected %0d actual %0d", exp_r.entries_held,
                       tdata[2*FIELD_W +: HELD_W]);
                error_count++;
            end
            if (pad !== '0) begin
                $error("tdata pad expected 0 actual %0h", pad);
                error_count++;
            end
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

    endclass

endpackage

// ----- dv/sorted_table_floor_lookup_test.sv -----
// Testbench for sorted_table_floor_lookup: directed and random command streams, scoreboard checks.
module sorted_table_floor_lookup_test;

    timeunit 1ns;
    timeprecision 1ps;

    import stfl_pkg::*;
    import stfl_lookup_scoreboard_pkg::*;

    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam int          TOTAL_WORDS = 1450;
    localparam int          CYCLE_LIMIT = 3_000_000;
    localparam int          DRAIN_CYCLES = 300;
    localparam logic [31:0] KEY_MAX     = 32'hFFFF_FFFF;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [TUSER_W-1:0]   s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [TUSER_W-1:0]   m_axis_tuser;

    lookup_scoreboard sb = new();

    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;
    int unsigned words_sent = 0;
    int unsigned cycle_count = 0;
    int unsigned drv_fill = 0;
    logic [31:0] drv_keys[$];

    sorted_table_floor_lookup i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sorted_table_floor_lookup_test: done, errors");
            $finish;
        end
    end

    // monitors
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready)
            sb.note_command(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata);
    end

    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic send_command(logic [1:0] mode, logic [31:0] key, logic [31:0] payload);
        case (words_sent * 4 / TOTAL_WORDS)
            0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1:       begin src_idle_pct = 60; snk_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  snk_stall_pct = 60; end
            default: begin src_idle_pct = 26; snk_stall_pct = 26; end
        endcase
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {payload, key};
        do @(posedge aclk); while (!s_axis_tready);
        case (mode)
            MODE_CLEAR: begin
                drv_fill = 0;
                drv_keys.delete();
            end
            MODE_APPEND: begin
                if (drv_fill < CAPACITY_DEF) begin
                    drv_fill++;
                    drv_keys.push_back(key);
                end
            end
            default: ;
        endcase
        if (mode != MODE_UNUSED)
            words_sent++;
    endtask

    function automatic logic [31:0] pick_key();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 35)
            return $urandom_range(63);
        if (sel < 45) begin
            case ($urandom_range(3))
                0:       return '0;
                1:       return KEY_MAX;
                2:       return KEY_MAX - 1;
                default: return 32'd1;
            endcase
        end
        if (sel < 60 && drv_keys.size() != 0)
            return drv_keys[$urandom_range(drv_keys.size() - 1)];
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_query();
        logic [31:0] k;
        int unsigned sel;
        sel = $urandom_range(99);
        if (drv_keys.size() == 0 || sel < 25)
            return pick_key();
        k = drv_keys[$urandom_range(drv_keys.size() - 1)];
        if (sel < 50)
            return k;
        if (sel < 75)
            return k - 1;
        return k + 1;
    endfunction

    function automatic logic [31:0] pick_payload();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned episode;
        int unsigned target;
        int unsigned appends;
        int unsigned pick;
        bit          full_run;

        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_CLEAR;
        m_axis_tready = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty table, extremes, ties, floor below/at/above, unused mode
        send_command(MODE_SEARCH, 32'd0, 32'h1234_5678);
        send_command(MODE_SEARCH, KEY_MAX, '1);
        send_command(MODE_UNUSED, '1, '1);
        send_command(MODE_APPEND, 32'd100, 32'h0000_0000);
        send_command(MODE_APPEND, 32'd100, 32'hFFFF_FFFF);
        send_command(MODE_APPEND, 32'd0, 32'h0000_0001);
        send_command(MODE_APPEND, KEY_MAX, 32'h0000_0002);
        send_command(MODE_APPEND, 32'd50, 32'hA5A5_5A5A);
        send_command(MODE_SEARCH, 32'd99, '0);
        send_command(MODE_SEARCH, 32'd100, '0);
        send_command(MODE_SEARCH, 32'd0, '0);
        send_command(MODE_SEARCH, KEY_MAX, '0);
        send_command(MODE_SEARCH, KEY_MAX - 1, '0);
        send_command(MODE_UNUSED, 32'd7, 32'd9);
        send_command(MODE_CLEAR, '1, '1);
        send_command(MODE_SEARCH, 32'd100, '0);
        send_command(MODE_APPEND, 32'd200, 32'h5A5A_A5A5);
        send_command(MODE_SEARCH, 32'd199, '0);
        send_command(MODE_SEARCH, 32'd201, '0);
        send_command(MODE_APPEND, 32'd200, 32'hC0DE_0001);
        send_command(MODE_SEARCH, 32'd200, '0);
        send_command(MODE_CLEAR, '0, '0);

        // random: clear, fill to a target with searches, unused and clear words mixed in; some runs fill up
        episode = 0;
        while (words_sent < TOTAL_WORDS) begin
            full_run = (episode % 13 == 1);
            target   = full_run ? CAPACITY_DEF + $urandom_range(2, 5) : $urandom_range(0, 40);
            send_command(MODE_CLEAR, $urandom, $urandom);
            appends = 0;
            while (appends < target) begin
                pick = $urandom_range(99);
                if (pick < (full_run ? 80 : 55)) begin
                    send_command(MODE_APPEND, pick_key(), pick_payload());
                    appends++;
                end else if (pick < 97) begin
                    send_command(MODE_SEARCH, pick_query(), $urandom);
                end else if (pick < 99 || full_run) begin
                    send_command(MODE_UNUSED, $urandom, $urandom);
                end else begin
                    send_command(MODE_CLEAR, $urandom, $urandom);
                end
            end
            repeat ($urandom_range(1, 8))
                send_command(MODE_SEARCH, pick_query(), $urandom);
            episode++;
        end

        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.error_count == 0 && sb.pending() == 0)
            $display("sorted_table_floor_lookup_test: done, clean");
        else
            $display("sorted_table_floor_lookup_test: done, errors");
        $finish;
    end

endmodule
